// ===== rtl/free_block_coalescer_defines.svh =====
// ----------------------------------------------------------------------------
// Free block coalescer assertion macros
// Immediate and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef FREE_BLOCK_COALESCER_DEFINES_SVH
`define FREE_BLOCK_COALESCER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define FBC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Free block coalescer package
// Shared defaults, opcode and result codes, and the result flag bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbc_pkg;

  localparam int TableDepthDef = 32;
  localparam int AddrBitsDef   = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_BLOCK = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic kind;
    logic status;
    logic is_empty;
    logic last;
  } res_flags_t;

endpackage

// ===== rtl/fbc_table_mem.sv =====
// ----------------------------------------------------------------------------
// Free block table memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbc_table_mem import fbc_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int ADDR_BITS   = AddrBitsDef,
  localparam int IdxW       = $clog2(TABLE_DEPTH),
  localparam int EntW       = 2 * ADDR_BITS
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  logic [EntW-1:0] wdata_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output logic [EntW-1:0] rdata_o
);

  logic [EntW-1:0] mem_q [TABLE_DEPTH];
  logic [EntW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fbc_out_reg.sv =====
// ----------------------------------------------------------------------------
// Free block coalescer output register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbc_out_reg import fbc_pkg::*; #(
  parameter int ADDR_BITS = AddrBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  res_flags_t           flags_i,
  input  logic [ADDR_BITS-1:0] start_i,
  input  logic [ADDR_BITS:0]   size_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 result_kind_o,
  output logic                 status_o,
  output logic [ADDR_BITS-1:0] out_start_o,
  output logic [ADDR_BITS:0]   out_size_o,
  output logic                 is_empty_o,
  output logic                 last_o
);

  logic                 valid_q, valid_d;
  res_flags_t           flags_q;
  logic [ADDR_BITS-1:0] start_q;
  logic [ADDR_BITS:0]   size_q;

  // free when empty or being drained this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      flags_q <= flags_i;
      start_q <= start_i;
      size_q  <= size_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign result_kind_o = flags_q.kind;
  assign status_o      = flags_q.status;
  assign is_empty_o    = flags_q.is_empty;
  assign last_o        = flags_q.last;
  assign out_start_o   = start_q;
  assign out_size_o    = size_q;

endmodule

// ===== rtl/fbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Free block coalescer control
// Sorted insert by a downward read-shift walk, and a pipelined merge walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbc_ctrl import fbc_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int ADDR_BITS   = AddrBitsDef,
  localparam int IdxW       = $clog2(TABLE_DEPTH),
  localparam int CntW       = $clog2(TABLE_DEPTH + 1),
  localparam int EntW       = 2 * ADDR_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 opcode_i,
  input  logic [ADDR_BITS-1:0] block_start_i,
  input  logic [ADDR_BITS-1:0] block_size_i,
  output logic                 mem_we_o,
  output logic [IdxW-1:0]      mem_waddr_o,
  output logic [EntW-1:0]      mem_wdata_o,
  output logic                 mem_re_o,
  output logic [IdxW-1:0]      mem_raddr_o,
  input  logic [EntW-1:0]      mem_rdata_i,
  output logic                 res_load_o,
  output res_flags_t           res_flags_o,
  output logic [ADDR_BITS-1:0] res_start_o,
  output logic [ADDR_BITS:0]   res_size_o,
  input  logic                 res_free_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_DUMP,
    S_FLUSH,
    S_RESP
  } state_e;

  localparam logic [CntW-1:0] DepthCnt = CntW'(TABLE_DEPTH);

  state_e               state_q, state_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      idx_q, idx_d;
  logic [CntW-1:0]      proc_idx_q, proc_idx_d;
  logic                 dv_q, dv_d;
  logic                 empty_q, empty_d;
  logic                 status_q, status_d;
  logic [ADDR_BITS-1:0] new_start_q, new_start_d;
  logic [ADDR_BITS-1:0] new_size_q, new_size_d;
  logic [ADDR_BITS-1:0] cur_start_q, cur_start_d;
  logic [ADDR_BITS:0]   cur_size_q, cur_size_d;

  logic [ADDR_BITS-1:0] rd_start;
  logic [ADDR_BITS-1:0] rd_size;
  logic [ADDR_BITS+1:0] cur_end;
  logic                 merge;
  logic                 first;
  logic                 need_emit;
  logic                 can_proc;
  logic                 issue;
  logic [CntW-1:0]      idx_up;

  assign rd_start  = mem_rdata_i[EntW-1:ADDR_BITS];
  assign rd_size   = mem_rdata_i[ADDR_BITS-1:0];
  assign cur_end   = {2'b00, cur_start_q} + {1'b0, cur_size_q};
  assign merge     = (cur_end == {2'b00, rd_start});
  assign first     = (proc_idx_q == '0);
  assign need_emit = dv_q && !first && !merge;
  assign can_proc  = dv_q && (!need_emit || res_free_i);
  assign issue     = (state_q == S_DUMP) && (idx_q < cnt_q) && (!dv_q || can_proc);
  assign idx_up    = idx_q + 1'b1;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    proc_idx_d  = proc_idx_q;
    dv_d        = dv_q;
    empty_d     = empty_q;
    status_d    = status_q;
    new_start_d = new_start_q;
    new_size_d  = new_size_q;
    cur_start_d = cur_start_q;
    cur_size_d  = cur_size_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = {new_start_q, new_size_q};
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    res_load_o  = 1'b0;
    res_flags_o = '{kind: KIND_ACK, status: STATUS_OK, is_empty: 1'b0, last: 1'b1};
    res_start_o = '0;
    res_size_o  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_INSERT) begin
            new_start_d = block_start_i;
            new_size_d  = block_size_i;
            if (cnt_q == DepthCnt) begin
              status_d = STATUS_FULL;
              state_d  = S_RESP;
            end else if (cnt_q == '0) begin
              mem_we_o    = 1'b1;
              mem_wdata_o = {block_start_i, block_size_i};
              cnt_d       = cnt_q + 1'b1;
              status_d    = STATUS_OK;
              state_d     = S_RESP;
            end else begin
              // walk down from the top entry
              mem_re_o    = 1'b1;
              mem_raddr_o = IdxW'(cnt_q - 1'b1);
              idx_d       = cnt_q - 1'b1;
              status_d    = STATUS_OK;
              state_d     = S_INS;
            end
          end else begin
            idx_d   = '0;
            dv_d    = 1'b0;
            empty_d = (cnt_q == '0);
            state_d = (cnt_q == '0) ? S_FLUSH : S_DUMP;
          end
        end
      end

      S_INS: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = IdxW'(idx_up);
        if (rd_start >= new_start_q) begin
          // shift this entry up one place
          mem_wdata_o = mem_rdata_i;
          if (idx_q == '0) begin
            state_d = S_INS_LAST;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = IdxW'(idx_q - 1'b1);
            idx_d       = idx_q - 1'b1;
          end
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_RESP;
        end
      end

      S_INS_LAST: begin
        mem_we_o = 1'b1;
        cnt_d    = cnt_q + 1'b1;
        state_d  = S_RESP;
      end

      S_DUMP: begin
        if (issue) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = IdxW'(idx_q);
          idx_d       = idx_up;
          proc_idx_d  = idx_q;
        end
        dv_d = issue ? 1'b1 : (can_proc ? 1'b0 : dv_q);
        if (can_proc) begin
          if (first) begin
            cur_start_d = rd_start;
            cur_size_d  = {1'b0, rd_size};
          end else if (merge) begin
            cur_size_d = cur_size_q + {1'b0, rd_size};
          end else begin
            res_load_o  = 1'b1;
            res_flags_o = '{kind: KIND_BLOCK, status: STATUS_OK, is_empty: 1'b0,
                            last: 1'b0};
            res_start_o = cur_start_q;
            res_size_o  = cur_size_q;
            cur_start_d = rd_start;
            cur_size_d  = {1'b0, rd_size};
          end
          if (proc_idx_q == cnt_q - 1'b1) begin
            state_d = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (res_free_i) begin
          res_load_o  = 1'b1;
          res_flags_o = '{kind: KIND_BLOCK, status: STATUS_OK, is_empty: empty_q,
                          last: 1'b1};
          res_start_o = empty_q ? '0 : cur_start_q;
          res_size_o  = empty_q ? '0 : cur_size_q;
          cnt_d       = '0;
          state_d     = S_IDLE;
        end
      end

      S_RESP: begin
        if (res_free_i) begin
          res_load_o  = 1'b1;
          res_flags_o = '{kind: KIND_ACK, status: status_q, is_empty: 1'b0, last: 1'b1};
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      proc_idx_q  <= '0;
      dv_q        <= 1'b0;
      empty_q     <= 1'b0;
      status_q    <= STATUS_OK;
      new_start_q <= '0;
      new_size_q  <= '0;
      cur_start_q <= '0;
      cur_size_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      proc_idx_q  <= proc_idx_d;
      dv_q        <= dv_d;
      empty_q     <= empty_d;
      status_q    <= status_d;
      new_start_q <= new_start_d;
      new_size_q  <= new_size_d;
      cur_start_q <= cur_start_d;
      cur_size_q  <= cur_size_d;
    end
  end

endmodule

// ===== rtl/free_block_coalescer.sv =====
// Insert: with an empty or full table the result is loaded from the response state; else
//   the walk reads one entry a cycle downward, shifts up each with start at or above the
//   new start, writes the new entry, then loads. Dump: one entry a cycle through the table
//   read port while the output is free, then the final load (no reads with an empty table).
// Each result shows in the cycle after its load; a new transaction is taken in the cycle
//   after the last load. Output stalls hold loads. Reset clears count and control only.
// ----------------------------------------------------------------------------
// Free block coalescer
// Address-ordered free block table with neighbor coalescing on dump.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "free_block_coalescer_defines.svh"

module free_block_coalescer import fbc_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int ADDR_BITS   = AddrBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 opcode_i,
  input  logic [ADDR_BITS-1:0] block_start_i,
  input  logic [ADDR_BITS-1:0] block_size_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 result_kind_o,
  output logic                 status_o,
  output logic [ADDR_BITS-1:0] out_start_o,
  output logic [ADDR_BITS:0]   out_size_o,
  output logic                 is_empty_o,
  output logic                 last_o
);

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int EntW = 2 * ADDR_BITS;

  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  logic [EntW-1:0]      mem_wdata;
  logic                 mem_re;
  logic [IdxW-1:0]      mem_raddr;
  logic [EntW-1:0]      mem_rdata;
  logic                 res_load;
  res_flags_t           res_flags;
  logic [ADDR_BITS-1:0] res_start;
  logic [ADDR_BITS:0]   res_size;
  logic                 res_free;

  fbc_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ADDR_BITS  (ADDR_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .block_start_i(block_start_i),
    .block_size_i (block_size_i),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata),
    .res_load_o   (res_load),
    .res_flags_o  (res_flags),
    .res_start_o  (res_start),
    .res_size_o   (res_size),
    .res_free_i   (res_free)
  );

  fbc_table_mem #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ADDR_BITS  (ADDR_BITS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  fbc_out_reg #(
    .ADDR_BITS(ADDR_BITS)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (res_load),
    .flags_i      (res_flags),
    .start_i      (res_start),
    .size_i       (res_size),
    .free_o       (res_free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_kind_o(result_kind_o),
    .status_o     (status_o),
    .out_start_o  (out_start_o),
    .out_size_o   (out_size_o),
    .is_empty_o   (is_empty_o),
    .last_o       (last_o)
  );

  // a result is never loaded over one the consumer has not taken
  `FBC_ASSERT_SAME(a_load_free, clk_i, rst_ni, res_load, !out_valid_o || !out_stall_i, "result overwritten")
  // the shift walk never reads and writes the same entry in one cycle
  `FBC_ASSERT_SAME(a_mem_no_clash, clk_i, rst_ni, mem_we && mem_re, mem_waddr != mem_raddr, "read write clash")
  // an accepted transaction makes the input side busy in the next cycle
  `FBC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "not busy after accept")

endmodule
